FILE: design/saa_pkg.sv
`timescale 1ns / 1ps
package saa_pkg;
	localparam int PARTICLES  = 1024;
	localparam int MAX_COUNT  = 255;
	localparam int DIMENSIONS = 3;
	localparam int IDX_W      = 10;
	localparam int SUM_W      = 40;
	localparam int CNT_W      = 8;
	localparam int Q_W        = 32;
	localparam int ROW_W      = 6 * SUM_W + CNT_W + 1;

	typedef enum logic {KIND_ADD = 1'b0, KIND_READ = 1'b1} kind_t;

	typedef struct packed {
		logic              kind;
		logic              cluster_used;
		logic              slot_filled;
		logic [IDX_W-1:0]  particle_index;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
	} in_t;

	typedef struct packed {
		logic [IDX_W-1:0]   out_index;
		logic signed [31:0] avg_pos_x;
		logic signed [31:0] avg_pos_y;
		logic signed [31:0] avg_pos_z;
		logic signed [31:0] avg_vel_x;
		logic signed [31:0] avg_vel_y;
		logic signed [31:0] avg_vel_z;
		logic [CNT_W-1:0]   contributions;
		logic               overflowed;
	} out_t;

	// classified command passed front to back
	typedef struct packed {
		logic                  rd;
		logic                  ok;
		logic [IDX_W-1:0]      idx;
		logic [5:0][Q_W-1:0]   v;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_FETCH, ST_ADD, ST_DIV, ST_OUT, ST_CLEAR
	} st_t;
endpackage

FILE: design/scatter_accumulate_average.sv
`timescale 1ns / 1ps
// channel | direction | handshake
// in      | input     | in_valid / in_stall, in_data
// out     | output    | out_valid / out_stall, out_data
// Add beat: the back end steps through fetch, then read-modify-write.
// Readout: the six averages are computed in turn by the one shared bit-serial divider.
// After reset a clearing pass runs over all 1024 rows of the row memory; input
// beats queue (two deep) but are not executed until it ends.
// A stalled result holds the back end; the front queue keeps accepting until it is full.
module scatter_accumulate_average import saa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_data
);
	logic q_valid, q_pop;
	cmd_t q_cmd;

	saa_front u_front (.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.q_valid, .q_pop, .q_cmd);
	saa_back u_back (.clk, .arst_n, .q_valid, .q_pop, .q_cmd,
		.out_valid, .out_stall, .out_data);
endmodule

FILE: design/saa_front.sv
`timescale 1ns / 1ps
module saa_front import saa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_t  in_data,
	output logic q_valid,
	input  logic q_pop,
	output cmd_t q_cmd
);
	cmd_t       mem_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	cmd_t       c;
	logic       push, keep;

	always_comb begin
		c.rd  = in_data.kind;
		c.ok  = in_data.particle_index < IDX_W'(PARTICLES - 1) ||
			in_data.particle_index == IDX_W'(PARTICLES - 1);
		c.idx = in_data.particle_index;
		c.v   = {in_data.pos_x, in_data.pos_y, in_data.pos_z,
			in_data.vel_x, in_data.vel_y, in_data.vel_z};
	end

	assign in_stall = cnt_q == 2'd2;
	assign keep     = in_data.kind == KIND_READ ||
		(in_data.cluster_used && in_data.slot_filled && c.ok);
	assign push     = in_valid && !in_stall && keep;
	assign q_valid  = cnt_q != 2'd0;
	assign q_cmd    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (q_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

FILE: design/saa_div.sv
`timescale 1ns / 1ps
module saa_div import saa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  sum,
	input  logic [CNT_W-1:0]  den,
	output logic              done,
	output logic [Q_W-1:0]    quo
);
	logic [SUM_W-1:0] qt_q;
	logic [CNT_W:0]   rem_q;
	logic [5:0]       n_q;
	logic             neg_q, busy_q;
	logic [CNT_W:0]   sh;
	logic [SUM_W-1:0] mag, qs;
	logic             ge;

	assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : sum;
	assign sh  = {rem_q[CNT_W-1:0], qt_q[SUM_W-1]};
	assign ge  = sh >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) busy_q <= 1'b1;
			else if (busy_q && n_q == 6'(SUM_W - 1)) begin
				busy_q <= 1'b0; done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qt_q <= mag; rem_q <= '0; n_q <= '0; neg_q <= sum[SUM_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? sh - {1'b0, den} : sh;
			qt_q  <= {qt_q[SUM_W-2:0], ge};
			n_q   <= n_q + 6'd1;
		end
	end

	always_comb begin
		qs = neg_q ? SUM_W'(-qt_q) : qt_q;
		if (!neg_q && qt_q > SUM_W'(32'h7fffffff)) quo = 32'h7fffffff;
		else if (neg_q && qt_q > SUM_W'(33'h80000000)) quo = 32'h80000000;
		else quo = qs[Q_W-1:0];
	end
endmodule

FILE: design/saa_back.sv
`timescale 1ns / 1ps
module saa_back import saa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_pop,
	input  cmd_t q_cmd,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_data
);
	logic [ROW_W-1:0] mem [PARTICLES];
	logic [ROW_W-1:0] row_q, wdat;
	logic [IDX_W-1:0] clr_q;
	logic             clring_q, we;
	st_t              st_q, st_d;
	cmd_t             cmd_q;
	logic [2:0]       k_q;
	logic [5:0][Q_W-1:0] avg_q;
	logic [CNT_W-1:0] cnt;
	logic             ovf, dstart, ddone;
	logic [SUM_W-1:0] dsum;
	logic [Q_W-1:0]   dq;
	logic [5:0][SUM_W-1:0] sums, nsums;

	assign sums = row_q[ROW_W-1 -: 6*SUM_W];
	assign cnt  = row_q[CNT_W:1];
	assign ovf  = row_q[0];

	always_comb begin
		for (int i = 0; i < 6; i++)
			nsums[i] = (i % 3 < 3 - DIMENSIONS) ? sums[i] :
				sums[i] + SUM_W'(signed'(cmd_q.v[i]));
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:  if (!clring_q && q_valid) st_d = ST_FETCH;
			ST_FETCH: st_d = cmd_q.rd ? ST_DIV : ST_ADD;
			ST_ADD:   st_d = ST_IDLE;
			ST_DIV:   if (ddone && k_q == 3'd5) st_d = ST_OUT;
			ST_OUT:   if (!out_stall) st_d = ST_CLEAR;
			ST_CLEAR: st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop  = st_q == ST_IDLE && !clring_q && q_valid;
		dstart = (st_q == ST_FETCH && cmd_q.rd) || (st_q == ST_DIV && ddone && k_q != 3'd5);
		dsum   = sums[st_q == ST_FETCH ? 3'd5 : 3'd4 - k_q];
		out_valid = st_q == ST_OUT;
		we     = clring_q || st_q == ST_ADD || (st_q == ST_CLEAR && cmd_q.ok);
		if (clring_q || st_q == ST_CLEAR) wdat = '0;
		else if (cnt == CNT_W'(MAX_COUNT)) wdat = {sums, cnt, 1'b1};
		else wdat = {nsums, cnt + CNT_W'(1), ovf};
	end

	always_ff @(posedge clk) begin
		if (we) mem[clring_q ? clr_q : cmd_q.idx] <= wdat;
		if (q_pop) cmd_q <= q_cmd;
		row_q <= mem[q_pop ? q_cmd.idx : cmd_q.idx];
		if (st_q == ST_FETCH) k_q <= '0;
		else if (ddone) begin
			avg_q[3'd5 - k_q] <= (cnt == '0 || !cmd_q.ok) ? '0 : dq;
			k_q <= k_q + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; clring_q <= 1'b1; clr_q <= '0;
		end else begin
			st_q <= st_d;
			if (clring_q) begin
				clr_q <= clr_q + IDX_W'(1);
				if (clr_q == IDX_W'(PARTICLES - 1)) clring_q <= 1'b0;
			end
		end
	end

	assign out_data = '{out_index: cmd_q.idx,
		avg_pos_x: avg_q[5], avg_pos_y: avg_q[4], avg_pos_z: avg_q[3],
		avg_vel_x: avg_q[2], avg_vel_y: avg_q[1], avg_vel_z: avg_q[0],
		contributions: cmd_q.ok ? cnt : '0, overflowed: cmd_q.ok & ovf};

	saa_div u_div (.clk, .arst_n, .start(dstart), .sum(dsum), .den(cnt),
		.done(ddone), .quo(dq));
endmodule

FILE: design/saa_checker.sv
`timescale 1ns / 1ps
module saa_checker import saa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out hold");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.contributions <= CNT_W'(MAX_COUNT)) else $error("count");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.contributions == '0 |-> out_data.avg_pos_x == '0)
		else $error("zero avg");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid) else $error("double out");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid)) else $error("stall without beat");
endmodule

bind scatter_accumulate_average saa_checker u_chk (.clk, .arst_n, .in_valid,
	.in_stall, .out_valid, .out_stall, .out_data);
